FILE: src/htp_pkg.sv
`default_nettype none

package htp_pkg;

    localparam logic [4:0] ST_METHOD_START       = 5'd0;
    localparam logic [4:0] ST_METHOD             = 5'd1;
    localparam logic [4:0] ST_URI                = 5'd2;
    localparam logic [4:0] ST_VER_H              = 5'd3;
    localparam logic [4:0] ST_VER_T1             = 5'd4;
    localparam logic [4:0] ST_VER_T2             = 5'd5;
    localparam logic [4:0] ST_VER_P              = 5'd6;
    localparam logic [4:0] ST_VER_SLASH          = 5'd7;
    localparam logic [4:0] ST_MAJOR_START        = 5'd8;
    localparam logic [4:0] ST_MAJOR              = 5'd9;
    localparam logic [4:0] ST_MINOR_START        = 5'd10;
    localparam logic [4:0] ST_MINOR              = 5'd11;
    localparam logic [4:0] ST_NL1                = 5'd12;
    localparam logic [4:0] ST_LINE_START         = 5'd13;
    localparam logic [4:0] ST_LWS                = 5'd14;
    localparam logic [4:0] ST_NAME               = 5'd15;
    localparam logic [4:0] ST_SPACE_BEFORE_VALUE = 5'd16;
    localparam logic [4:0] ST_VALUE              = 5'd17;
    localparam logic [4:0] ST_NL2                = 5'd18;
    localparam logic [4:0] ST_NL3                = 5'd19;
    localparam logic [4:0] ST_BODY               = 5'd20;
    localparam logic [4:0] ST_ERROR              = 5'd21;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URI    = 3'd2;
    localparam logic [2:0] CLS_NAME   = 3'd3;
    localparam logic [2:0] CLS_VALUE  = 3'd4;
    localparam logic [2:0] CLS_BODY   = 3'd5;

    localparam logic [1:0] STS_PARSING  = 2'd0;
    localparam logic [1:0] STS_COMPLETE = 2'd1;
    localparam logic [1:0] STS_ERROR    = 2'd2;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CTL_MAX = 8'd31;
    localparam logic [7:0] ACC_MAX  = 8'd255;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0] byte_class;
        logic [7:0] data_out;
        logic       new_header;
        logic [1:0] status;
        logic [7:0] version_major;
        logic [7:0] version_minor;
    } t_out;

    typedef struct packed {
        logic [4:0] parse_state;
        logic       seen_header;
        logic [7:0] major_acc;
        logic [7:0] minor_acc;
    } t_state;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CH_CTL_MAX) || (c == CH_DEL);
    endfunction

    function automatic logic is_tspecial(input logic [7:0] c);
        logic r;
        case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
            8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
            8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_tspecial(c);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
        logic [11:0] v;
        logic [7:0]  d;
        d = c - CH_ZERO;
        v = {4'b0, acc} * 12'd10 + {8'b0, d[3:0]};
        return (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/htp_step.sv
`default_nettype none

module htp_step (
    input  wire htp_pkg::t_state i_state,
    input  wire htp_pkg::t_in    i_item,
    output htp_pkg::t_state      o_state,
    output htp_pkg::t_out        o_result
);

    logic [7:0] c;
    logic [4:0] nx;
    logic [2:0] cls;
    logic       newh;
    logic [1:0] sts;
    logic       bad;
    logic       seen;
    logic [7:0] maj;
    logic [7:0] mnr;

    assign c = i_item.data_byte;

    always_comb begin
        nx   = i_state.parse_state;
        cls  = htp_pkg::CLS_NONE;
        newh = 1'b0;
        sts  = htp_pkg::STS_PARSING;
        bad  = 1'b0;
        seen = i_state.seen_header;
        maj  = i_state.major_acc;
        mnr  = i_state.minor_acc;
        unique case (i_state.parse_state) inside
            htp_pkg::ST_METHOD_START: begin
                if (htp_pkg::is_token(c)) begin
                    nx  = htp_pkg::ST_METHOD;
                    cls = htp_pkg::CLS_METHOD;
                end else bad = 1'b1;
            end
            htp_pkg::ST_METHOD: begin
                if (c == htp_pkg::CH_SP) nx = htp_pkg::ST_URI;
                else if (htp_pkg::is_token(c)) cls = htp_pkg::CLS_METHOD;
                else bad = 1'b1;
            end
            htp_pkg::ST_URI: begin
                if (c == htp_pkg::CH_SP) nx = htp_pkg::ST_VER_H;
                else if (htp_pkg::is_ctl(c)) bad = 1'b1;
                else cls = htp_pkg::CLS_URI;
            end
            htp_pkg::ST_VER_H: begin
                if (c == htp_pkg::CH_H) nx = htp_pkg::ST_VER_T1; else bad = 1'b1;
            end
            htp_pkg::ST_VER_T1: begin
                if (c == htp_pkg::CH_T) nx = htp_pkg::ST_VER_T2; else bad = 1'b1;
            end
            htp_pkg::ST_VER_T2: begin
                if (c == htp_pkg::CH_T) nx = htp_pkg::ST_VER_P; else bad = 1'b1;
            end
            htp_pkg::ST_VER_P: begin
                if (c == htp_pkg::CH_P) nx = htp_pkg::ST_VER_SLASH; else bad = 1'b1;
            end
            htp_pkg::ST_VER_SLASH: begin
                if (c == htp_pkg::CH_SLASH) begin
                    maj = '0;
                    mnr = '0;
                    nx  = htp_pkg::ST_MAJOR_START;
                end else bad = 1'b1;
            end
            htp_pkg::ST_MAJOR_START: begin
                if (htp_pkg::is_digit(c)) begin
                    maj = htp_pkg::acc_digit(i_state.major_acc, c);
                    nx  = htp_pkg::ST_MAJOR;
                end else bad = 1'b1;
            end
            htp_pkg::ST_MAJOR: begin
                if (c == htp_pkg::CH_DOT) nx = htp_pkg::ST_MINOR_START;
                else if (htp_pkg::is_digit(c)) maj = htp_pkg::acc_digit(i_state.major_acc, c);
                else bad = 1'b1;
            end
            htp_pkg::ST_MINOR_START: begin
                if (htp_pkg::is_digit(c)) begin
                    mnr = htp_pkg::acc_digit(i_state.minor_acc, c);
                    nx  = htp_pkg::ST_MINOR;
                end else bad = 1'b1;
            end
            htp_pkg::ST_MINOR: begin
                if (c == htp_pkg::CH_CR) nx = htp_pkg::ST_NL1;
                else if (htp_pkg::is_digit(c)) mnr = htp_pkg::acc_digit(i_state.minor_acc, c);
                else bad = 1'b1;
            end
            htp_pkg::ST_NL1, htp_pkg::ST_NL2: begin
                if (c == htp_pkg::CH_LF) nx = htp_pkg::ST_LINE_START; else bad = 1'b1;
            end
            htp_pkg::ST_LINE_START: begin
                if (c == htp_pkg::CH_CR) nx = htp_pkg::ST_NL3;
                else if (i_state.seen_header && (c == htp_pkg::CH_SP || c == htp_pkg::CH_HT))
                    nx = htp_pkg::ST_LWS;
                else if (htp_pkg::is_token(c)) begin
                    seen = 1'b1;
                    newh = 1'b1;
                    cls  = htp_pkg::CLS_NAME;
                    nx   = htp_pkg::ST_NAME;
                end else bad = 1'b1;
            end
            htp_pkg::ST_LWS: begin
                if (c == htp_pkg::CH_CR) nx = htp_pkg::ST_NL2;
                else if (c == htp_pkg::CH_SP || c == htp_pkg::CH_HT) nx = htp_pkg::ST_LWS;
                else if (htp_pkg::is_ctl(c)) bad = 1'b1;
                else begin
                    cls = htp_pkg::CLS_VALUE;
                    nx  = htp_pkg::ST_VALUE;
                end
            end
            htp_pkg::ST_NAME: begin
                if (c == htp_pkg::CH_COLON) nx = htp_pkg::ST_SPACE_BEFORE_VALUE;
                else if (htp_pkg::is_token(c)) cls = htp_pkg::CLS_NAME;
                else bad = 1'b1;
            end
            htp_pkg::ST_SPACE_BEFORE_VALUE: begin
                if (c == htp_pkg::CH_SP) nx = htp_pkg::ST_VALUE; else bad = 1'b1;
            end
            htp_pkg::ST_VALUE: begin
                if (c == htp_pkg::CH_CR) nx = htp_pkg::ST_NL2;
                else if (htp_pkg::is_ctl(c)) bad = 1'b1;
                else cls = htp_pkg::CLS_VALUE;
            end
            htp_pkg::ST_NL3: begin
                if (c == htp_pkg::CH_LF) begin
                    sts = htp_pkg::STS_COMPLETE;
                    nx  = htp_pkg::ST_BODY;
                end else bad = 1'b1;
            end
            htp_pkg::ST_BODY: begin
                cls = htp_pkg::CLS_BODY;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        if (bad) begin
            nx   = htp_pkg::ST_ERROR;
            cls  = htp_pkg::CLS_NONE;
            newh = 1'b0;
            sts  = htp_pkg::STS_ERROR;
        end
        if (i_item.func) begin
            nx   = htp_pkg::ST_METHOD_START;
            cls  = htp_pkg::CLS_NONE;
            newh = 1'b0;
            sts  = htp_pkg::STS_PARSING;
            seen = 1'b0;
            maj  = '0;
            mnr  = '0;
        end
    end

    assign o_state.parse_state = nx;
    assign o_state.seen_header = seen;
    assign o_state.major_acc   = maj;
    assign o_state.minor_acc   = mnr;

    assign o_result.byte_class    = cls;
    assign o_result.data_out      = c;
    assign o_result.new_header    = newh;
    assign o_result.status        = sts;
    assign o_result.version_major = maj;
    assign o_result.version_minor = mnr;

endmodule

`default_nettype wire

FILE: src/http_request_header_parser_top.sv
// Output: the result of a transaction accepted at an edge is held in the output register from that edge on.
// Throughput: one byte per cycle; the parse state register is updated through a combinational step,
// and the output register takes a new result whenever it is empty or being drained.
// Reset: synchronous, active low; parse state returns to method start, header flag
// and version accumulators clear, and the output register empties.
`default_nettype none

module http_request_header_parser_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire htp_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output htp_pkg::t_out       o_out_data
);

    htp_pkg::t_state r_state;
    htp_pkg::t_state n_state;
    htp_pkg::t_out   n_result;
    htp_pkg::t_out   r_result;
    logic            r_out_valid;
    logic            in_fire;

    htp_step u_step (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.parse_state <= htp_pkg::ST_METHOD_START;
            r_state.seen_header <= 1'b0;
            r_state.major_acc   <= '0;
            r_state.minor_acc   <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_result;

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.status == htp_pkg::STS_ERROR)
        |-> (r_result.byte_class == htp_pkg::CLS_NONE && !r_result.new_header))
        else $error("error result carries a class or header start");

    a_newh_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.new_header)
        |-> (r_result.byte_class == htp_pkg::CLS_NAME && r_state.seen_header))
        else $error("header start without name class or header flag");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.func)
        |=> (r_state.parse_state == htp_pkg::ST_METHOD_START && !r_state.seen_header
             && r_state.major_acc == '0 && r_state.minor_acc == '0))
        else $error("restart did not clear parser state");

    a_complete_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_result.status == htp_pkg::STS_COMPLETE)
        |=> (r_state.parse_state == htp_pkg::ST_BODY
             && r_result.byte_class == htp_pkg::CLS_NONE))
        else $error("header completion did not enter body");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in_data.func && r_state.parse_state == htp_pkg::ST_ERROR)
        |=> (r_state.parse_state == htp_pkg::ST_ERROR
             && r_result.status == htp_pkg::STS_ERROR))
        else $error("error state left without restart");

endmodule

`default_nettype wire
